// ===== rtl/periodic_event_timer_table_assert.svh =====
// Assertion macros for the periodic event timer table.
// Included by the top level; no other dependencies.
`ifndef PERIODIC_EVENT_TIMER_TABLE_ASSERT_SVH
`define PERIODIC_EVENT_TIMER_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
// General clocked property with active-low reset gating
`define PET_ASSERT_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("periodic_event_timer_table: assertion failed");
// Same-cycle implication
`define PET_ASSERT_IMPLY(label, clk, rstn, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (expr)) \
        else $error("periodic_event_timer_table: implication failed");
`else
`define PET_ASSERT_CLK(label, clk, rstn, prop)
`define PET_ASSERT_IMPLY(label, clk, rstn, cond, expr)
`endif
`endif

// ===== rtl/pet_pkg.sv =====
// Shared types and constants for the periodic event timer table.
// No dependencies; used by pet_cell and periodic_event_timer_table.
package pet_pkg;

    localparam int PET_MAX_EVENTS = 16;

    // Request opcodes
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_CHANGE = 2'd2;
    localparam logic [1:0] OP_DELETE = 2'd3;

    // Result kinds
    localparam logic [1:0] KIND_FIRED = 2'd0;
    localparam logic [1:0] KIND_OK    = 2'd1;
    localparam logic [1:0] KIND_FAIL  = 2'd2;
    localparam logic [1:0] KIND_DONE  = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] now_ms;
        logic [7:0]  event_id;
        logic [15:0] period;
        logic [7:0]  target_tag;
    } pet_req_t;

    typedef struct packed {
        logic [1:0] result_kind;
        logic [7:0] event_id_out;
        logic [7:0] target_out;
        logic       last_in_run;
    } pet_res_t;

    // Payload of one table slot
    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] period;
        logic [31:0] last_fire;
        logic [7:0]  target;
    } pet_slot_t;

    typedef struct packed {
        logic      valid;
        pet_slot_t slot;
    } pet_entry_t;

    // Per-cycle command broadcast to every cell
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_PUSH,
        CELL_PULL,
        CELL_ROTATE,
        CELL_EDIT
    } pet_cell_op_t;

    typedef struct packed {
        pet_cell_op_t op;
        logic [7:0]   key_id;
        logic [15:0]  new_period;
        logic [7:0]   new_target;
    } pet_cell_ctrl_t;

endpackage

// ===== rtl/pet_cell.sv =====
// One slot of the event table chain: holds an entry and trades it with neighbors.
// Depends on pet_pkg.
module pet_cell (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  pet_pkg::pet_cell_ctrl_t ctrl,
    input  pet_pkg::pet_entry_t     prev_in,
    input  pet_pkg::pet_entry_t     next_in,
    input  logic                    seen_in,
    output pet_pkg::pet_entry_t     entry_out,
    output logic                    seen_out
);
    import pet_pkg::*;

    logic      valid_reg, valid_next;
    pet_slot_t slot_reg, slot_next;
    logic      match;

    // id compare; seen ripples a match toward the tail
    assign match     = valid_reg && (slot_reg.id == ctrl.key_id);
    assign seen_out  = seen_in | match;
    assign entry_out = '{valid: valid_reg, slot: slot_reg};

    // next entry per broadcast command
    always_comb begin
        valid_next = valid_reg;
        slot_next  = slot_reg;
        case (ctrl.op)
            CELL_PUSH: begin
                valid_next = prev_in.valid;
                slot_next  = prev_in.slot;
            end
            CELL_PULL: begin
                if (seen_out) begin
                    valid_next = next_in.valid;
                    slot_next  = next_in.slot;
                end
            end
            CELL_ROTATE: begin
                valid_next = next_in.valid;
                slot_next  = next_in.slot;
            end
            CELL_EDIT: begin
                if (match) begin
                    slot_next.period = ctrl.new_period;
                    if (ctrl.new_target != 8'd0) begin
                        slot_next.target = ctrl.new_target;
                    end
                end
            end
            default: begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg <= slot_next;
    end

endmodule

// ===== rtl/periodic_event_timer_table.sv =====
// Top level of the periodic event timer table: control sequencer and cell chain.
// Depends on pet_pkg, pet_cell and periodic_event_timer_table_assert.svh.
//
// Usage:
//   Requests enter on s_valid/s_ready/s_req (tick, add, change, delete).
//   Results leave on m_valid/m_ready/m_res; the last result of a request
//   has last_in_run set. One request is in work at a time.
//   Tick: the table of MAX_EVENTS cells rotates one position per cycle past
//   the head cell, where the elapsed time is checked, while the receiver
//   takes any fired result; a stall on a fired result holds the rotation.
//   The done result follows the scan. A tick that repeats the last
//   scanned time skips the scan. Add searches ids one candidate per cycle.
//   s_ready rises again once the final result sits in the output register,
//   so the next request is taken while that result waits.
//   Reset (aresetn low, synchronous) empties the table and clears the id
//   counter and time registers at once; no clearing pass is needed.
//   A stalled receiver holds the scan in place: the output register keeps
//   its result and the chain does not advance past a firing entry.
`include "periodic_event_timer_table_assert.svh"
module periodic_event_timer_table #(
    parameter int MAX_EVENTS = pet_pkg::PET_MAX_EVENTS
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  pet_pkg::pet_req_t s_req,
    output logic              m_valid,
    input  logic              m_ready,
    output pet_pkg::pet_res_t m_res
);
    import pet_pkg::*;

    localparam int CW  = $clog2(MAX_EVENTS + 1);
    localparam int SCW = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_IDSRCH,
        ST_SCAN,
        ST_EMIT
    } state_t;

    state_t           state_reg;
    pet_req_t         req_reg;
    pet_res_t         m_res_reg;
    pet_res_t         pend_reg;
    logic             m_valid_reg;
    logic [CW-1:0]    count_reg;
    logic [SCW-1:0]   scan_cnt_reg;
    logic [7:0]       id_counter_reg;
    logic [7:0]       cand_reg;
    logic [31:0]      current_ms_reg;
    logic [31:0]      last_scanned_reg;

    pet_entry_t       ent [MAX_EVENTS];
    logic             seen [MAX_EVENTS+1];
    pet_cell_ctrl_t   cell_ctrl;
    pet_entry_t       push_entry;
    pet_entry_t       tail_entry;
    pet_entry_t       head;
    logic             any_hit;
    logic             out_free;
    logic             fire;
    logic             scan_step;
    logic [31:0]      elapsed;
    logic             add_bad;
    logic             res_load;
    logic [1:0]       exec_kind;
    state_t           exec_next;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_res    = m_res_reg;
    assign out_free = !m_valid_reg || m_ready;

    // Cell chain
    assign seen[0] = 1'b0;
    assign any_hit = seen[MAX_EVENTS];
    assign head    = ent[0];

    for (genvar i = 0; i < MAX_EVENTS; i++) begin : g_cell
        pet_entry_t prev_e, next_e;
        if (i == 0) begin : g_first
            assign prev_e = push_entry;
        end else begin : g_mid_p
            assign prev_e = ent[i-1];
        end
        if (i == MAX_EVENTS - 1) begin : g_last
            assign next_e = tail_entry;
        end else begin : g_mid_n
            assign next_e = ent[i+1];
        end
        pet_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (cell_ctrl),
            .prev_in   (prev_e),
            .next_in   (next_e),
            .seen_in   (seen[i]),
            .entry_out (ent[i]),
            .seen_out  (seen[i+1])
        );
    end

    // Head check for the tick scan
    assign elapsed   = req_reg.now_ms - head.slot.last_fire;
    assign fire      = head.valid && (elapsed >= {16'd0, head.slot.period});
    assign scan_step = !fire || out_free;
    assign add_bad   = (count_reg == CW'(MAX_EVENTS)) || (req_reg.period == 16'd0)
                       || (req_reg.target_tag == 8'd0);

    // Output register takes a fired result during the scan or the final one
    assign res_load = ((state_reg == ST_SCAN) && scan_step && fire)
                      || ((state_reg == ST_EMIT) && out_free);

    // Chain command
    always_comb begin
        cell_ctrl.op         = CELL_HOLD;
        cell_ctrl.key_id     = req_reg.event_id;
        cell_ctrl.new_period = req_reg.period;
        cell_ctrl.new_target = req_reg.target_tag;
        push_entry.valid          = 1'b1;
        push_entry.slot.id        = cand_reg;
        push_entry.slot.period    = req_reg.period;
        push_entry.slot.last_fire = current_ms_reg;
        push_entry.slot.target    = req_reg.target_tag;
        tail_entry = '0;
        case (state_reg)
            ST_EXEC: begin
                case (req_reg.opcode)
                    OP_CHANGE: begin
                        if (req_reg.period != 16'd0) begin
                            cell_ctrl.op = CELL_EDIT;
                        end
                    end
                    OP_DELETE: cell_ctrl.op = CELL_PULL;
                    default:   cell_ctrl.op = CELL_HOLD;
                endcase
            end
            ST_IDSRCH: begin
                cell_ctrl.key_id = cand_reg;
                if (!any_hit) begin
                    cell_ctrl.op = CELL_PUSH;
                end
            end
            ST_SCAN: begin
                if (scan_step) begin
                    cell_ctrl.op = CELL_ROTATE;
                    tail_entry   = head;
                    if (fire) begin
                        tail_entry.slot.last_fire = req_reg.now_ms;
                    end
                end
            end
            default: cell_ctrl.op = CELL_HOLD;
        endcase
    end

    // Result kind and follow-up state of the request in work
    always_comb begin
        exec_kind = KIND_FAIL;
        exec_next = ST_EMIT;
        case (req_reg.opcode)
            OP_TICK: begin
                exec_kind = KIND_DONE;
                if (req_reg.now_ms != last_scanned_reg) begin
                    exec_next = ST_SCAN;
                end
            end
            OP_ADD: begin
                if (!add_bad) begin
                    exec_next = ST_IDSRCH;
                end
            end
            OP_CHANGE: begin
                if (any_hit && (req_reg.period != 16'd0)) begin
                    exec_kind = KIND_OK;
                end
            end
            OP_DELETE: begin
                if (any_hit) begin
                    exec_kind = KIND_OK;
                end
            end
            default: exec_kind = KIND_FAIL;
        endcase
    end

    // Sequencer, counters and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            m_valid_reg      <= 1'b0;
            count_reg        <= '0;
            id_counter_reg   <= 8'd0;
            current_ms_reg   <= 32'd0;
            last_scanned_reg <= 32'd0;
        end else begin
            // valid set on load, cleared once taken
            if (res_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        req_reg   <= s_req;
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    pend_reg     <= '{result_kind: exec_kind, event_id_out: 8'd0,
                                      target_out: 8'd0, last_in_run: 1'b1};
                    state_reg    <= exec_next;
                    scan_cnt_reg <= '0;
                    cand_reg     <= id_counter_reg + 8'd1;
                    if (req_reg.opcode == OP_TICK) begin
                        current_ms_reg   <= req_reg.now_ms;
                        last_scanned_reg <= req_reg.now_ms;
                    end
                    if ((req_reg.opcode == OP_DELETE) && any_hit) begin
                        count_reg <= count_reg - CW'(1);
                    end
                end
                ST_IDSRCH: begin
                    if (any_hit) begin
                        cand_reg <= cand_reg + 8'd1;
                    end else begin
                        id_counter_reg <= cand_reg;
                        count_reg      <= count_reg + CW'(1);
                        pend_reg       <= '{result_kind: KIND_OK, event_id_out: cand_reg,
                                            target_out: 8'd0, last_in_run: 1'b1};
                        state_reg      <= ST_EMIT;
                    end
                end
                ST_SCAN: begin
                    if (scan_step) begin
                        if (fire) begin
                            m_res_reg <= '{result_kind: KIND_FIRED,
                                           event_id_out: head.slot.id,
                                           target_out: head.slot.target,
                                           last_in_run: 1'b0};
                        end
                        scan_cnt_reg <= scan_cnt_reg + SCW'(1);
                        if (scan_cnt_reg == SCW'(MAX_EVENTS - 1)) begin
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_res_reg <= pend_reg;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Checks
    logic [MAX_EVENTS-1:0] valid_vec;
    logic [MAX_EVENTS-1:0] valid_inc;
    logic                  table_compact;
    logic                  pushing;
    logic                  head_is_new;
    logic                  mid_run;
    for (genvar k = 0; k < MAX_EVENTS; k++) begin : g_vvec
        assign valid_vec[k] = ent[k].valid;
    end
    assign valid_inc     = valid_vec + MAX_EVENTS'(1);
    assign table_compact = ((valid_vec & valid_inc) == '0);
    assign pushing       = (state_reg == ST_IDSRCH) && !any_hit;
    assign head_is_new   = ent[0].valid && (ent[0].slot.id == id_counter_reg);
    assign mid_run       = m_valid_reg && !m_res_reg.last_in_run;

    `PET_ASSERT_CLK(a_count_matches_cells, aclk, aresetn, ($countones(valid_vec) == count_reg))
    `PET_ASSERT_IMPLY(a_table_compact, aclk, aresetn, state_reg != ST_SCAN, table_compact)
    `PET_ASSERT_CLK(a_push_at_head, aclk, aresetn, pushing |=> head_is_new)
    `PET_ASSERT_IMPLY(a_only_fired_midrun, aclk, aresetn, mid_run, m_res_reg.result_kind == KIND_FIRED)

endmodule
